// ----- rtl/gpst_pkg.sv -----
package gpst_pkg;

  localparam int unsigned TDATA_IN_W  = 16;
  localparam int unsigned TDATA_OUT_W = 16;

  localparam logic [7:0] ABORT_BYTE = 8'hFF;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TIMEOUT  = 2'd1;
  localparam logic [1:0] ST_DESELECT = 2'd2;

  localparam logic [1:0] REG_CLOCK_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_ACK_DELAY     = 2'd1;
  localparam logic [1:0] REG_ACK_WIDTH     = 2'd2;

  localparam logic [15:0] CLOCK_TIMEOUT_RST = 16'd100;
  localparam logic [9:0]  ACK_DELAY_RST     = 10'd10;
  localparam logic [9:0]  ACK_WIDTH_RST     = 10'd3;

  typedef struct packed {
    logic       command_level;
    logic       clock_level;
    logic       select_level;
    logic       ack_after;
    logic [7:0] tx_byte;
    logic       start_req;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] rx_byte;
    logic       byte_done;
    logic       busy_res;
    logic       ack_drive_low;
    logic       data_drive_low;
  } res_item_t;

  typedef struct packed {
    logic [15:0] clock_timeout_ticks;
    logic [9:0]  ack_delay_ticks;
    logic [9:0]  ack_width_ticks;
  } cfg_regs_t;

endpackage

// ----- rtl/gpst_core.sv -----
module gpst_core
  import gpst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  input  cfg_regs_t cfg,
  output res_item_t res
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_FALL = 3'd1,
    PH_RISE = 3'd2,
    PH_ADLY = 3'd3,
    PH_AHLD = 3'd4
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  bit_index_r, bit_index_nxt;
  logic [7:0]  out_shift_r, out_shift_nxt;
  logic [7:0]  in_shift_r, in_shift_nxt;
  logic        held_cmd_r, held_cmd_nxt;
  logic [15:0] tick_count_r, tick_count_nxt;
  logic        ack_wanted_r, ack_wanted_nxt;
  logic        data_low_r, data_low_nxt;

  logic [15:0] tick_inc;
  logic        timed_out;
  logic        done;
  logic [7:0]  rx;
  logic [1:0]  st;

  assign tick_inc  = tick_count_r + 16'd1;
  assign timed_out = (tick_count_r >= cfg.clock_timeout_ticks);

  always_comb begin
    phase_nxt      = phase_r;
    bit_index_nxt  = bit_index_r;
    out_shift_nxt  = out_shift_r;
    in_shift_nxt   = in_shift_r;
    held_cmd_nxt   = held_cmd_r;
    tick_count_nxt = tick_count_r;
    ack_wanted_nxt = ack_wanted_r;
    data_low_nxt   = data_low_r;
    done           = 1'b0;
    rx             = 8'd0;
    st             = ST_OK;
    case (phase_r)
      PH_IDLE: begin
        if (item.start_req) begin
          out_shift_nxt  = item.tx_byte;
          ack_wanted_nxt = item.ack_after;
          bit_index_nxt  = 3'd0;
          in_shift_nxt   = 8'd0;
          tick_count_nxt = 16'd0;
          phase_nxt      = PH_FALL;
        end
      end
      PH_FALL, PH_RISE: begin
        if (item.clock_level == (phase_r == PH_RISE)) begin
          tick_count_nxt = 16'd0;
          if (phase_r == PH_FALL) begin
            held_cmd_nxt = item.command_level;
            data_low_nxt = ~out_shift_r[bit_index_r];
            phase_nxt    = PH_RISE;
          end else begin
            in_shift_nxt = in_shift_r | (8'(held_cmd_r) << bit_index_r);
            if (bit_index_r == 3'd7) begin
              data_low_nxt = 1'b0;
              done         = 1'b1;
              rx           = in_shift_nxt;
              if (!ack_wanted_r) begin
                phase_nxt = PH_IDLE;
              end else if (cfg.ack_delay_ticks == 10'd0) begin
                phase_nxt = PH_AHLD;
              end else begin
                phase_nxt = PH_ADLY;
              end
            end else begin
              bit_index_nxt = bit_index_r + 3'd1;
              phase_nxt     = PH_FALL;
            end
          end
        end else if (timed_out || item.select_level) begin
          data_low_nxt = 1'b0;
          done         = 1'b1;
          rx           = ABORT_BYTE;
          st           = timed_out ? ST_TIMEOUT : ST_DESELECT;
          phase_nxt    = PH_IDLE;
        end else begin
          tick_count_nxt = tick_inc;
        end
      end
      PH_ADLY: begin
        tick_count_nxt = tick_inc;
        if (tick_inc >= {6'd0, cfg.ack_delay_ticks}) begin
          tick_count_nxt = 16'd0;
          phase_nxt      = PH_AHLD;
        end
      end
      PH_AHLD: begin
        tick_count_nxt = tick_inc;
        if (tick_inc >= {6'd0, cfg.ack_width_ticks}) begin
          tick_count_nxt = 16'd0;
          phase_nxt      = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    res.data_drive_low = data_low_nxt;
    res.ack_drive_low  = (phase_nxt == PH_AHLD);
    res.busy_res       = (phase_nxt != PH_IDLE);
    res.byte_done      = done;
    res.rx_byte        = rx;
    res.status         = st;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_index_r  <= 3'd0;
      out_shift_r  <= 8'd0;
      in_shift_r   <= 8'd0;
      held_cmd_r   <= 1'b0;
      tick_count_r <= 16'd0;
      ack_wanted_r <= 1'b0;
      data_low_r   <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      bit_index_r  <= bit_index_nxt;
      out_shift_r  <= out_shift_nxt;
      in_shift_r   <= in_shift_nxt;
      held_cmd_r   <= held_cmd_nxt;
      tick_count_r <= tick_count_nxt;
      ack_wanted_r <= ack_wanted_nxt;
      data_low_r   <= data_low_nxt;
    end
  end

endmodule

// ----- rtl/game_pad_serial_slave_transfer.sv -----
// Channel   Ports                       Carries
// in_       tvalid/tready/tdata[15:0]   one pin sample tick with start request
// out_      tvalid/tready/tdata[15:0]   pin drives, busy, byte end and status
// cfg_      valid/ready/index/data      timeout, ack delay, ack width
//
// One word in and one word out per cycle when neither side stalls.
// A word passes an input register and a result register.
// The input side stays ready while the result register drains or is free.
// Reset (rst_n low, synchronous) clears state and loads register defaults.
module game_pad_serial_slave_transfer
  import gpst_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // [0] start_req, [8:1] tx_byte, [9] ack_after, [10] select_level,
  // [11] clock_level, [12] command_level, [15:13] zero
  input  logic [TDATA_IN_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [0] data_drive_low, [1] ack_drive_low, [2] busy_res, [3] byte_done,
  // [11:4] rx_byte, [13:12] status, [15:14] zero
  output logic [TDATA_OUT_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data
);

  cfg_regs_t cfg_r;
  in_item_t  item_r;
  logic      item_valid_r;
  res_item_t res;
  res_item_t res_r;
  logic      res_valid_r;
  logic      advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clock_timeout_ticks <= CLOCK_TIMEOUT_RST;
      cfg_r.ack_delay_ticks     <= ACK_DELAY_RST;
      cfg_r.ack_width_ticks     <= ACK_WIDTH_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CLOCK_TIMEOUT: cfg_r.clock_timeout_ticks <= cfg_data;
        REG_ACK_DELAY:     cfg_r.ack_delay_ticks     <= cfg_data[9:0];
        REG_ACK_WIDTH:     cfg_r.ack_width_ticks     <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  assign advance   = item_valid_r && (!res_valid_r || out_tready);
  assign in_tready = !item_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tready) begin
      item_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= in_item_t'(in_tdata[12:0]);
    end
  end

  gpst_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (item_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= 1'b1;
    end else if (out_tready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = res_valid_r;
  assign out_tdata  = {2'b00, res_r};

endmodule

// ----- tb/tb_game_pad_serial_slave_transfer.sv -----
module tb_game_pad_serial_slave_transfer;
  import gpst_pkg::*;

  typedef enum logic [2:0] {
    LINK_IDLE,
    LINK_FALL,
    LINK_RISE,
    LINK_ACK_WAIT,
    LINK_ACK_HOLD
  } link_phase_t;

  typedef struct packed {
    in_item_t  w;
    logic      pinned;
    res_item_t res;
  } script_row_t;

  localparam int SCRIPT_ROWS = 26;
  localparam logic [7:0] CMD_PATTERN = 8'hC3;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [TDATA_IN_W-1:0]  in_tdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [TDATA_OUT_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [1:0]             cfg_index = '0;
  logic [15:0]            cfg_data = '0;

  bit          calm = 1'b0;
  int          mismatches = 0;
  int          sent_words = 0;
  res_item_t   pin_result_q[$];
  script_row_t script [SCRIPT_ROWS];

  logic [15:0] timeout_cfg = CLOCK_TIMEOUT_RST;
  logic [9:0]  ack_delay_cfg = ACK_DELAY_RST;
  logic [9:0]  ack_width_cfg = ACK_WIDTH_RST;

  link_phase_t lk_phase = LINK_IDLE;
  logic [2:0]  lk_bit = '0;
  logic [7:0]  lk_tx = '0;
  logic [7:0]  lk_rx = '0;
  logic        lk_cmd = 1'b0;
  logic [15:0] lk_ticks = '0;
  logic        lk_ack_req = 1'b0;
  logic        lk_data_low = 1'b0;

  res_item_t got;
  res_item_t want;

  game_pad_serial_slave_transfer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 35);
  end

  // missed edge: timeout first, then deselect, else count the tick
  function automatic logic [1:0] edge_miss(logic sel);
    if (lk_ticks >= timeout_cfg) return ST_TIMEOUT;
    if (sel) return ST_DESELECT;
    lk_ticks = lk_ticks + 16'd1;
    return ST_OK;
  endfunction

  function automatic res_item_t serial_step(in_item_t w);
    res_item_t  r;
    logic [1:0] why;
    r = '0;
    why = ST_OK;
    case (lk_phase)
      LINK_IDLE: begin
        if (w.start_req) begin
          lk_tx = w.tx_byte;
          lk_ack_req = w.ack_after;
          lk_bit = 3'd0;
          lk_rx = 8'h00;
          lk_ticks = 16'd0;
          lk_phase = LINK_FALL;
        end
      end
      LINK_FALL: begin
        if (!w.clock_level) begin
          lk_cmd = w.command_level;
          lk_data_low = ~lk_tx[lk_bit];
          lk_ticks = 16'd0;
          lk_phase = LINK_RISE;
        end else begin
          why = edge_miss(w.select_level);
        end
      end
      LINK_RISE: begin
        if (w.clock_level) begin
          lk_rx[lk_bit] = lk_rx[lk_bit] | lk_cmd;
          lk_ticks = 16'd0;
          if (lk_bit == 3'd7) begin
            lk_data_low = 1'b0;
            r.byte_done = 1'b1;
            r.rx_byte = lk_rx;
            if (!lk_ack_req) lk_phase = LINK_IDLE;
            else if (ack_delay_cfg == 10'd0) lk_phase = LINK_ACK_HOLD;
            else lk_phase = LINK_ACK_WAIT;
          end else begin
            lk_bit = lk_bit + 3'd1;
            lk_phase = LINK_FALL;
          end
        end else begin
          why = edge_miss(w.select_level);
        end
      end
      LINK_ACK_WAIT: begin
        lk_ticks = lk_ticks + 16'd1;
        if (lk_ticks >= {6'd0, ack_delay_cfg}) begin
          lk_ticks = 16'd0;
          lk_phase = LINK_ACK_HOLD;
        end
      end
      LINK_ACK_HOLD: begin
        lk_ticks = lk_ticks + 16'd1;
        if (lk_ticks >= {6'd0, ack_width_cfg}) begin
          lk_ticks = 16'd0;
          lk_phase = LINK_IDLE;
        end
      end
      default: begin
        lk_phase = LINK_IDLE;
      end
    endcase
    if (why != ST_OK) begin
      lk_data_low = 1'b0;
      r.byte_done = 1'b1;
      r.rx_byte = ABORT_BYTE;
      r.status = why;
      lk_phase = LINK_IDLE;
    end
    r.data_drive_low = lk_data_low;
    r.ack_drive_low = (lk_phase == LINK_ACK_HOLD);
    r.busy_res = (lk_phase != LINK_IDLE);
    return r;
  endfunction

  function automatic in_item_t mk(logic start, logic [7:0] tx, logic ackr, logic sel,
                                  logic sclk, logic cmd);
    in_item_t w;
    w.start_req = start;
    w.tx_byte = tx;
    w.ack_after = ackr;
    w.select_level = sel;
    w.clock_level = sclk;
    w.command_level = cmd;
    return w;
  endfunction

  function automatic res_item_t res(logic ddl, logic adl, logic busy, logic done,
                                    logic [7:0] rx, logic [1:0] st);
    res_item_t r;
    r.data_drive_low = ddl;
    r.ack_drive_low = adl;
    r.busy_res = busy;
    r.byte_done = done;
    r.rx_byte = rx;
    r.status = st;
    return r;
  endfunction

  function automatic in_item_t pin_word(logic sclk, logic may_start);
    logic [12:0] raw;
    in_item_t    w;
    raw = 13'($urandom);
    w = raw;
    w.start_req = may_start & ($urandom_range(9) == 0);
    w.select_level = ($urandom_range(79) == 0);
    w.clock_level = sclk;
    return w;
  endfunction

  function automatic int wait_len();
    if ($urandom_range(11) == 0) return (timeout_cfg < 16'd23) ? int'(timeout_cfg) + 1 : 24;
    return ($urandom_range(3) == 0) ? 1 : 0;
  endfunction

  task automatic send_word(in_item_t w, logic pinned, res_item_t pin_exp);
    res_item_t predicted;
    @(negedge clk);
    while (!calm && $urandom_range(99) < 35) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata <= {3'b000, w};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predicted = serial_step(w);
    pin_result_q.push_back(pinned ? pin_exp : predicted);
    sent_words++;
  endtask

  task automatic random_byte();
    in_item_t w;
    int       gap;
    int       span;
    w = pin_word(1'b1, 1'b0);
    w.start_req = 1'b1;
    send_word(w, 1'b0, '0);
    for (int b = 0; b < 8; b++) begin
      repeat (wait_len()) send_word(pin_word(1'b1, 1'b1), 1'b0, '0);
      send_word(pin_word(1'b0, 1'b1), 1'b0, '0);
      repeat (wait_len()) send_word(pin_word(1'b0, 1'b1), 1'b0, '0);
      send_word(pin_word(1'b1, 1'b1), 1'b0, '0);
    end
    // let the acknowledge run out, or cut it short now and then
    span = ack_delay_cfg + ack_width_cfg + 2;
    if (span > 300) span = 300;
    gap = ($urandom_range(7) == 0) ? 0 : $urandom_range(span);
    repeat (gap) send_word(pin_word(1'($urandom_range(1)), 1'b0), 1'b0, '0);
  endtask

  task automatic run_random(int n);
    int stop_at;
    stop_at = sent_words + n;
    while (sent_words < stop_at) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 6)) send_word(in_item_t'(13'($urandom)), 1'b0, '0);
      end else begin
        random_byte();
      end
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pin_result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CLOCK_TIMEOUT: timeout_cfg = val;
      REG_ACK_DELAY:     ack_delay_cfg = val[9:0];
      REG_ACK_WIDTH:     ack_width_cfg = val[9:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_regs(logic [15:0] tmo, logic [15:0] dly, logic [15:0] wid);
    write_reg(REG_CLOCK_TIMEOUT, tmo);
    write_reg(REG_ACK_DELAY, dly);
    write_reg(REG_ACK_WIDTH, wid);
  endtask

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got = res_item_t'(out_tdata[13:0]);
      if (pin_result_q.size() == 0) begin
        $display("%0t: word %0h with nothing expected", $time, got);
        mismatches++;
      end else begin
        want = pin_result_q.pop_front();
        check_field("data_drive_low", want.data_drive_low, got.data_drive_low);
        check_field("ack_drive_low", want.ack_drive_low, got.ack_drive_low);
        check_field("busy_res", want.busy_res, got.busy_res);
        check_field("byte_done", want.byte_done, got.byte_done);
        check_field("rx_byte", want.rx_byte, got.rx_byte);
        check_field("status", want.status, got.status);
      end
    end
  end

  initial begin
    script[0] = {mk(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0), 1'b1,
                 res(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, ST_OK)};
    script[1] = {mk(1'b0, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1), 1'b1,
                 res(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, ST_OK)};
    script[2] = {mk(1'b1, 8'hFE, 1'b0, 1'b0, 1'b1, 1'b0), 1'b1,
                 res(1'b0, 1'b0, 1'b1, 1'b0, 8'h00, ST_OK)};
    script[3] = {mk(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1), 1'b0, 14'h0};
    // drop select while driving low in the rising wait
    script[4] = {mk(1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0), 1'b1,
                 res(1'b0, 1'b0, 1'b0, 1'b1, ABORT_BYTE, ST_DESELECT)};
    script[5] = {mk(1'b1, 8'h3C, 1'b1, 1'b0, 1'b1, 1'b0), 1'b0, 14'h0};
    script[6] = {mk(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1), 1'b0, 14'h0};
    script[7] = {mk(1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0), 1'b0, 14'h0};
    // drop select while driving low in the falling wait
    script[8] = {mk(1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0), 1'b1,
                 res(1'b0, 1'b0, 1'b0, 1'b1, ABORT_BYTE, ST_DESELECT)};
    script[9] = {mk(1'b1, 8'h5A, 1'b1, 1'b0, 1'b1, 1'b0), 1'b0, 14'h0};
    for (int b = 0; b < 8; b++) begin
      script[10 + 2 * b] = {mk(b == 0, 8'hFF, 1'b0, 1'b0, 1'b0, CMD_PATTERN[b]), 1'b0, 14'h0};
      script[11 + 2 * b] = {mk(1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0), 1'b0, 14'h0};
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      send_word(script[i].w, script[i].pinned, script[i].res);
    end
    run_random(150);
    settle();

    load_regs(16'd1, 16'd0, 16'd0);
    run_random(200);
    settle();

    load_regs(16'hFFFF, 16'd1023, 16'd1023);
    run_random(60);
    settle();

    load_regs(16'd0, 16'd1, 16'd1);
    run_random(150);
    settle();

    calm = 1'b1;
    load_regs(16'($urandom_range(2, 12)), 16'($urandom_range(12)), 16'($urandom_range(6)));
    run_random(250);
    settle();
    calm = 1'b0;

    load_regs(16'($urandom_range(2, 12)), 16'($urandom_range(12)), 16'($urandom_range(6)));
    run_random(200);
    settle();

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
